// ===== hw/rtl/esfd_pkg.sv =====
// ----------------------------------------------------------------------------
// esfd_pkg
// Shared types and constants of the escaped sensor frame decoder.
// ----------------------------------------------------------------------------
package esfd_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_START_BYTE  = 3'd0;
  localparam logic [2:0] REG_ESCAPE_BYTE = 3'd1;
  localparam logic [2:0] REG_ESCAPE_MASK = 3'd2;
  localparam logic [2:0] REG_CODE_ADC_X  = 3'd3;
  localparam logic [2:0] REG_CODE_ADC_Y  = 3'd4;
  localparam logic [2:0] REG_CODE_ADC_Z  = 3'd5;
  localparam logic [2:0] REG_CODE_IMU    = 3'd6;
  localparam logic [2:0] REG_CODE_QUAT   = 3'd7;

  // register reset values
  localparam logic [7:0] RST_START_BYTE  = 8'd126;
  localparam logic [7:0] RST_ESCAPE_BYTE = 8'd125;
  localparam logic [7:0] RST_ESCAPE_MASK = 8'd32;
  localparam logic [7:0] RST_CODE_ADC_X  = 8'd1;
  localparam logic [7:0] RST_CODE_ADC_Y  = 8'd2;
  localparam logic [7:0] RST_CODE_ADC_Z  = 8'd3;
  localparam logic [7:0] RST_CODE_IMU    = 8'd4;
  localparam logic [7:0] RST_CODE_QUAT   = 8'd5;

  // fixed frame sizes, in 32-bit words
  localparam int IMU_WORDS_DEF  = 9;
  localparam int QUAT_WORDS_DEF = 4;

  // depth of the queue between front and back
  localparam int Q_DEPTH_DEF = 4;

  // result kinds (travel on out_tuser)
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_BAD     = 2'd2;

  // frame classes
  localparam logic [2:0] CLS_ADC_X = 3'd0;
  localparam logic [2:0] CLS_ADC_Y = 3'd1;
  localparam logic [2:0] CLS_ADC_Z = 3'd2;
  localparam logic [2:0] CLS_IMU   = 3'd3;
  localparam logic [2:0] CLS_QUAT  = 3'd4;

  localparam int OUT_DATA_W = 48;

  typedef enum logic [2:0] {
    PH_STANDBY,
    PH_TYPE,
    PH_LEN_L,
    PH_LEN_H,
    PH_DATA,
    PH_CHECK
  } phase_t;

  // type codes used by the frame parser
  typedef struct packed {
    logic [7:0] adc_x;
    logic [7:0] adc_y;
    logic [7:0] adc_z;
    logic [7:0] imu;
    logic [7:0] quat;
  } codes_t;

  // one unescaped symbol from the front end
  typedef struct packed {
    logic       sof;   // start byte seen
    logic [7:0] data;  // unmasked byte
  } token_t;

endpackage

// ===== hw/rtl/esfd_front.sv =====
// ----------------------------------------------------------------------------
// esfd_front
// Byte classifier: detects start and escape bytes and unmasks escaped bytes.
// ----------------------------------------------------------------------------
module esfd_front
  import esfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic [7:0] start_byte,
  input  logic [7:0] escape_byte,
  input  logic [7:0] escape_mask,
  output logic       push,
  output token_t     push_tok,
  input  logic       q_full
);

  logic esc_pend_r;
  logic esc_pend_nxt;
  logic xfer;
  logic is_start;
  logic is_esc;

  assign in_tready = !q_full;
  assign xfer      = in_tvalid && in_tready;
  assign is_start  = (in_tdata == start_byte);
  assign is_esc    = (in_tdata == escape_byte);

  always_comb begin
    push          = 1'b0;
    push_tok.sof  = is_start;
    push_tok.data = esc_pend_r ? (in_tdata ^ escape_mask) : in_tdata;
    esc_pend_nxt  = esc_pend_r;
    if (xfer) begin
      if (is_start) begin
        push = 1'b1;              // pending escape survives a start byte
      end else if (is_esc) begin
        esc_pend_nxt = 1'b1;
      end else begin
        push         = 1'b1;
        esc_pend_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_pend_r <= 1'b0;
    end else begin
      esc_pend_r <= esc_pend_nxt;
    end
  end

endmodule

// ===== hw/rtl/esfd_fifo.sv =====
// ----------------------------------------------------------------------------
// esfd_fifo
// Short token queue between the classifier and the frame parser.
// ----------------------------------------------------------------------------
module esfd_fifo
  import esfd_pkg::*;
#(
  parameter int DEPTH = Q_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  token_t push_tok,
  output logic   full,
  input  logic   pop,
  output logic   q_valid,
  output token_t q_tok
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  token_t         mem [DEPTH];
  logic [PW-1:0]  wp_r;
  logic [PW-1:0]  rp_r;
  logic [CW-1:0]  cnt_r;
  logic           do_push;
  logic           do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_tok   = mem[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(do_push) - CW'(do_pop);
    end
  end

  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count above depth");

  a_cnt_track : assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count lost a push");

  a_wr_rd_gap : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> wp_r == rp_r)
    else $error("empty queue with pointer gap");

endmodule

// ===== hw/rtl/esfd_back.sv =====
// ----------------------------------------------------------------------------
// esfd_back
// Frame parser: type, length, payload and checksum, with output register.
// ----------------------------------------------------------------------------
module esfd_back
  import esfd_pkg::*;
#(
  parameter int IMU_WORDS  = IMU_WORDS_DEF,
  parameter int QUAT_WORDS = QUAT_WORDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  codes_t                codes,
  input  logic                  q_valid,
  input  token_t                q_tok,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]            out_tuser
);

  localparam logic [15:0] IMU_LEN  = 16'(4 * IMU_WORDS);
  localparam logic [15:0] QUAT_LEN = 16'(4 * QUAT_WORDS);

  phase_t      ph_r,   ph_nxt;
  logic [2:0]  cls_r,  cls_nxt;
  logic [15:0] len_r,  len_nxt;
  logic [15:0] cnt_r,  cnt_nxt;
  logic [7:0]  csum_r, csum_nxt;

  logic        ov_r;
  logic [1:0]  o_kind_r,  o_kind_nxt;
  logic [2:0]  o_cls_r;
  logic [7:0]  o_byte_r,  o_byte_nxt;
  logic [15:0] o_idx_r,   o_idx_nxt;
  logic [7:0]  o_rcv_r,   o_rcv_nxt;
  logic [7:0]  o_cmp_r,   o_cmp_nxt;
  logic        o_set_r,   o_set_nxt;
  logic        emit;
  logic [7:0]  b;
  logic [15:0] cnt_inc;
  logic        good;

  assign pop     = q_valid && (!ov_r || out_tready);
  assign b       = q_tok.data;
  assign cnt_inc = cnt_r + 16'd1;
  assign good    = (b == csum_r);

  always_comb begin
    ph_nxt     = ph_r;
    cls_nxt    = cls_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    csum_nxt   = csum_r;
    emit       = 1'b0;
    o_kind_nxt = KIND_PAYLOAD;
    o_byte_nxt = '0;
    o_idx_nxt  = '0;
    o_rcv_nxt  = '0;
    o_cmp_nxt  = '0;
    o_set_nxt  = 1'b0;
    if (pop) begin
      if (q_tok.sof) begin
        ph_nxt = PH_TYPE;
      end else begin
        unique case (ph_r)
          PH_STANDBY: ;
          PH_TYPE: begin
            if (b == codes.adc_x) begin
              cls_nxt = CLS_ADC_X;
              ph_nxt  = PH_LEN_L;
            end else if (b == codes.adc_y) begin
              cls_nxt = CLS_ADC_Y;
              ph_nxt  = PH_LEN_L;
            end else if (b == codes.adc_z) begin
              cls_nxt = CLS_ADC_Z;
              ph_nxt  = PH_LEN_L;
            end else if (b == codes.imu) begin
              cls_nxt  = CLS_IMU;
              len_nxt  = IMU_LEN;
              cnt_nxt  = '0;
              csum_nxt = '0;
              ph_nxt   = (IMU_LEN == '0) ? PH_CHECK : PH_DATA;
            end else if (b == codes.quat) begin
              cls_nxt  = CLS_QUAT;
              len_nxt  = QUAT_LEN;
              cnt_nxt  = '0;
              csum_nxt = '0;
              ph_nxt   = (QUAT_LEN == '0) ? PH_CHECK : PH_DATA;
            end
          end
          PH_LEN_L: begin
            len_nxt = {8'd0, b};
            ph_nxt  = PH_LEN_H;
          end
          PH_LEN_H: begin
            len_nxt  = {b, len_r[7:0]};
            cnt_nxt  = '0;
            csum_nxt = '0;
            ph_nxt   = ({b, len_r[7:0]} == '0) ? PH_CHECK : PH_DATA;
          end
          PH_DATA: begin
            emit       = 1'b1;
            o_byte_nxt = b;
            o_idx_nxt  = cnt_r;
            csum_nxt   = csum_r ^ b;
            cnt_nxt    = cnt_inc;
            if (cnt_inc == len_r) begin
              ph_nxt = PH_CHECK;
            end
          end
          PH_CHECK: begin
            emit       = 1'b1;
            o_kind_nxt = good ? KIND_GOOD : KIND_BAD;
            o_rcv_nxt  = b;
            o_cmp_nxt  = csum_r;
            o_set_nxt  = good && (cls_r == CLS_ADC_Z);
            ph_nxt     = PH_STANDBY;
          end
          default: ph_nxt = PH_STANDBY;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_STANDBY;
      cls_r  <= '0;
      len_r  <= '0;
      cnt_r  <= '0;
      csum_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      cls_r  <= cls_nxt;
      len_r  <= len_nxt;
      cnt_r  <= cnt_nxt;
      csum_r <= csum_nxt;
      if (emit) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (emit) begin
      o_kind_r <= o_kind_nxt;
      o_cls_r  <= cls_r;
      o_byte_r <= o_byte_nxt;
      o_idx_r  <= o_idx_nxt;
      o_rcv_r  <= o_rcv_nxt;
      o_cmp_r  <= o_cmp_nxt;
      o_set_r  <= o_set_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = o_kind_r;
  assign out_tdata  = {4'd0, o_set_r, o_cmp_r, o_rcv_r, o_idx_r, o_byte_r, o_cls_r};

  a_cnt_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    ph_r == PH_DATA |-> cnt_r < len_r)
    else $error("payload count past length");

  a_check_ends : assert property (@(posedge clk) disable iff (!rst_n)
    pop && !q_tok.sof && ph_r == PH_CHECK |=> ph_r == PH_STANDBY && ov_r)
    else $error("checksum byte did not close frame");

  a_set_flag : assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && o_set_r |-> o_kind_r == KIND_GOOD && o_cls_r == CLS_ADC_Z)
    else $error("set flag on wrong result");

  a_no_overrun : assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_tready |-> !emit)
    else $error("result overwritten while stalled");

endmodule

// ===== hw/rtl/escaped_sensor_frame_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// escaped_sensor_frame_decoder_unit
// Byte-stuffed sensor frame decoder with XOR checksum check.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+----------------------------------
//  in_     | in  | in_tvalid/in_tready   | tdata[7:0] rx_byte
//  out_    | out | out_tvalid/out_tready | tuser kind, tdata class..set flag
//  cfg_    | in  | cfg_valid/cfg_ready   | cfg_index register, cfg_data value
//
//  One raw byte per cycle is taken while the queue has room; a transfer moves
//  through the classifier, a 4-entry token queue and the frame parser, and any
//  result it causes passes the queue and output register to out_. The parser's
//  one-token-per-cycle loop sets the sustained rate without stalls: 1 byte/cycle.
//  Reset is synchronous, active low; it restores register defaults and
//  puts the parser in standby. Output stalls fill the queue, then drop in_tready.
//
module escaped_sensor_frame_decoder_unit
  import esfd_pkg::*;
#(
  parameter int IMU_WORDS  = IMU_WORDS_DEF,
  parameter int QUAT_WORDS = QUAT_WORDS_DEF,
  parameter int Q_DEPTH    = Q_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input byte stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] rx_byte
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [2:0] frame_class, [10:3] payload_byte,
                                            // [26:11] byte_index,
                                            // [34:27] received_checksum,
                                            // [42:35] computed_checksum,
                                            // [43] adc_set_complete, [47:44] zero
  output logic [1:0]            out_tuser,  // [1:0] kind
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [7:0]            cfg_data
);

  logic [7:0] start_byte_r;
  logic [7:0] escape_byte_r;
  logic [7:0] escape_mask_r;
  codes_t     codes_r;

  logic       push;
  token_t     push_tok;
  logic       q_full;
  logic       q_valid;
  token_t     q_tok;
  logic       pop;

  // registers are always writable; the user must write them only while idle, as the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r  <= RST_START_BYTE;
      escape_byte_r <= RST_ESCAPE_BYTE;
      escape_mask_r <= RST_ESCAPE_MASK;
      codes_r.adc_x <= RST_CODE_ADC_X;
      codes_r.adc_y <= RST_CODE_ADC_Y;
      codes_r.adc_z <= RST_CODE_ADC_Z;
      codes_r.imu   <= RST_CODE_IMU;
      codes_r.quat  <= RST_CODE_QUAT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_BYTE:  start_byte_r  <= cfg_data;
        REG_ESCAPE_BYTE: escape_byte_r <= cfg_data;
        REG_ESCAPE_MASK: escape_mask_r <= cfg_data;
        REG_CODE_ADC_X:  codes_r.adc_x <= cfg_data;
        REG_CODE_ADC_Y:  codes_r.adc_y <= cfg_data;
        REG_CODE_ADC_Z:  codes_r.adc_z <= cfg_data;
        REG_CODE_IMU:    codes_r.imu   <= cfg_data;
        REG_CODE_QUAT:   codes_r.quat  <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: start/escape detection and unmasking
  esfd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .start_byte  (start_byte_r),
    .escape_byte (escape_byte_r),
    .escape_mask (escape_mask_r),
    .push        (push),
    .push_tok    (push_tok),
    .q_full      (q_full)
  );

  // decoupling queue
  esfd_fifo #(
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (push_tok),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_tok    (q_tok)
  );

  // back: frame parsing, checksum and result register
  esfd_back #(
    .IMU_WORDS  (IMU_WORDS),
    .QUAT_WORDS (QUAT_WORDS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .codes      (codes_r),
    .q_valid    (q_valid),
    .q_tok      (q_tok),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
